FILE: rtl/core/bir_pkg.sv
// Shared constants and types of the bilinear image rotation block.
`default_nettype none

package bir_pkg;

  // Default geometry and precision
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_VALUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_VALUE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd7;

  // Neighbour order of the four store reads
  localparam logic [1:0] TAP_TL = 2'd0;
  localparam logic [1:0] TAP_TR = 2'd1;
  localparam logic [1:0] TAP_BL = 2'd2;
  localparam logic [1:0] TAP_BR = 2'd3;

  // Result queue depth, also the bound on queries in flight
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [8:0]         image_width;
    logic [8:0]         image_height;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    logic signed [15:0] cos_value;
    logic signed [15:0] sin_value;
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
  } cfg_t;

  // One store read beat, aligned with the read data
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] idx;
    logic       in_image;
  } tap_t;

endpackage

`default_nettype wire

FILE: rtl/core/bir_if.sv
// Channel interfaces of the bilinear image rotation block.
`default_nettype none

interface bir_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] src_col;
  logic [7:0] src_row;
  logic [7:0] pixel_in;
  logic [9:0] out_col;
  logic [9:0] out_row;

  modport source (output valid, mode, src_col, src_row, pixel_in, out_col, out_row,
                  input ready);
  modport sink   (input valid, mode, src_col, src_row, pixel_in, out_col, out_row,
                  output ready);
endinterface

interface bir_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        inside_res;

  modport source (output valid, pixel_out, inside_res, input ready);
  modport sink   (input valid, pixel_out, inside_res, output ready);
endinterface

interface bir_cfg_if;
  import bir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bilinear_image_rotate.sv
// Top level of the bilinear image rotation block.
//
// Channels: in_ch_i carries items. mode 0 loads pixel_in at (src_col, src_row) into
// the image memory (no result); mode 1 queries output pixel (out_col, out_row) and
// yields one result on out_ch_o: pixel_out (8.8) and inside_res. cfg_ch_i writes the
// eight registers by index and is always ready; write only while the block is idle.
// An in-image query makes four neighbour reads through the single read port of the
// memory, and the memory stage takes no new item before its last read; a load or an
// out-of-image query does not hold that stage. A query passes the map stages, the
// store, the blend register and the result queue before its result is valid.
// A load is written in order with respect to queries, so a query sees exactly the
// loads accepted before it.
// Reset: registers return to width/height 256, centre 0, cos 1.0, sin 0, origin 0;
// pipeline and result queue empty. The image memory is not cleared.
// Stall: results queue four deep; when the receiver stalls, a query that reaches the
// memory stage with four results in flight waits there, and every item behind it holds.
`default_nettype none

module bilinear_image_rotate #(
  parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bir_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bir_in_if.sink    in_ch_i,
  bir_out_if.source out_ch_o,
  bir_cfg_if.sink   cfg_ch_i
);
  import bir_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  cfg_t cfg_q, cfg_d;

  // map -> store
  logic                 m_valid, m_ready, m_query, m_ld_ok, m_inside;
  logic [AW-1:0]        m_ld_addr;
  logic [7:0]           m_pixel;
  logic [XW-1:0]        m_x0;
  logic [YW-1:0]        m_y0;
  logic [FRAC_BITS-1:0] m_fx, m_fy;

  // store -> interp
  tap_t                 s_tap;
  logic [7:0]           s_pix;
  logic [FRAC_BITS-1:0] s_fx, s_fy;
  logic                 take_qry, credit_ok;

  // Configuration registers: always accept, decode by index
  assign cfg_ch_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_ch_i.valid) begin
      case (cfg_ch_i.index)
        REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_ch_i.data[8:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_ch_i.data[8:0];
        REG_CENTER_X:     cfg_d.center_x     = cfg_ch_i.data[11:0];
        REG_CENTER_Y:     cfg_d.center_y     = cfg_ch_i.data[11:0];
        REG_COS_VALUE:    cfg_d.cos_value    = $signed(cfg_ch_i.data);
        REG_SIN_VALUE:    cfg_d.sin_value    = $signed(cfg_ch_i.data);
        REG_ORIGIN_X:     cfg_d.origin_x     = $signed(cfg_ch_i.data[10:0]);
        REG_ORIGIN_Y:     cfg_d.origin_y     = $signed(cfg_ch_i.data[10:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 9'd256;
      cfg_q.image_height <= 9'd256;
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.cos_value    <= 16'sd16384;
      cfg_q.sin_value    <= '0;
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Coordinate pipeline: every item rides it so loads and queries stay in order
  bir_map #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_ch_i.valid),
    .ready_o  (in_ch_i.ready),
    .mode_i   (in_ch_i.mode),
    .src_col_i(in_ch_i.src_col),
    .src_row_i(in_ch_i.src_row),
    .pixel_i  (in_ch_i.pixel_in),
    .out_col_i(in_ch_i.out_col),
    .out_row_i(in_ch_i.out_row),
    .cfg_i    (cfg_q),
    .valid_o  (m_valid),
    .ready_i  (m_ready),
    .query_o  (m_query),
    .ld_ok_o  (m_ld_ok),
    .ld_addr_o(m_ld_addr),
    .pixel_o  (m_pixel),
    .inside_o (m_inside),
    .x0_o     (m_x0),
    .y0_o     (m_y0),
    .fx_o     (m_fx),
    .fy_o     (m_fy)
  );

  // Image memory: one write for loads, four sequenced reads per in-image query
  bir_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (m_valid),
    .ready_o    (m_ready),
    .query_i    (m_query),
    .ld_ok_i    (m_ld_ok),
    .ld_addr_i  (m_ld_addr),
    .pixel_i    (m_pixel),
    .inside_i   (m_inside),
    .x0_i       (m_x0),
    .y0_i       (m_y0),
    .fx_i       (m_fx),
    .fy_i       (m_fy),
    .credit_ok_i(credit_ok),
    .take_qry_o (take_qry),
    .tap_o      (s_tap),
    .pix_o      (s_pix),
    .fx_o       (s_fx),
    .fy_o       (s_fy)
  );

  // Blend and result queue
  bir_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tap_i       (s_tap),
    .pix_i       (s_pix),
    .fx_i        (s_fx),
    .fy_i        (s_fy),
    .take_qry_i  (take_qry),
    .credit_ok_o (credit_ok),
    .valid_o     (out_ch_o.valid),
    .ready_i     (out_ch_o.ready),
    .pixel_out_o (out_ch_o.pixel_out),
    .inside_res_o(out_ch_o.inside_res)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bir_map.sv
// Coordinate mapping pipeline: offset, rotate, round and bound check.
`default_nettype none

module bir_map #(
  parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bir_pkg::FRAC_BITS_DEF,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT),
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 mode_i,
  input  logic [7:0]           src_col_i,
  input  logic [7:0]           src_row_i,
  input  logic [7:0]           pixel_i,
  input  logic [9:0]           out_col_i,
  input  logic [9:0]           out_row_i,
  input  bir_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 query_o,
  output logic                 ld_ok_o,
  output logic [AW-1:0]        ld_addr_o,
  output logic [7:0]           pixel_o,
  output logic                 inside_o,
  output logic [XW-1:0]        x0_o,
  output logic [YW-1:0]        y0_o,
  output logic [FRAC_BITS-1:0] fx_o,
  output logic [FRAC_BITS-1:0] fy_o
);
  import bir_pkg::*;

  localparam int DW = 17;
  localparam int PW = 33;
  localparam int SW = 34;
  localparam int RS = 18 - FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(2 ** (RS - 1));

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // stage 1 payload
  logic                 q1_q, ok1_q;
  logic [AW-1:0]        addr1_q;
  logic [7:0]           pix1_q;
  logic signed [DW-1:0] dx1_q, dy1_q;
  // stage 2 payload
  logic                 q2_q, ok2_q;
  logic [AW-1:0]        addr2_q;
  logic [7:0]           pix2_q;
  logic signed [PW-1:0] pxc_q, pys_q, pxs_q, pyc_q;

  logic signed [11:0]   px_d, py_d;
  logic signed [DW-1:0] dx_d, dy_d;
  logic                 ld_ok_d;
  logic [AW-1:0]        ld_addr_d;

  logic signed [SW-1:0] sx_d, sy_d;
  logic signed [15:0]   x0_d, y0_d;
  logic signed [17:0]   w_eff, h_eff, x0p1, y0p1;
  logic                 inside_d;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;

  // stage 1: offsets relative to the centre, 4 fractional bits
  always_comb begin
    px_d      = $signed({2'b00, out_col_i}) + $signed({cfg_i.origin_x[10], cfg_i.origin_x});
    py_d      = $signed({2'b00, out_row_i}) + $signed({cfg_i.origin_y[10], cfg_i.origin_y});
    dx_d      = $signed({px_d[11], px_d, 4'b0000}) - $signed({5'b00000, cfg_i.center_x});
    dy_d      = $signed({py_d[11], py_d, 4'b0000}) - $signed({5'b00000, cfg_i.center_y});
    ld_ok_d   = (13'(src_col_i) < 13'(MAX_WIDTH)) && (13'(src_row_i) < 13'(MAX_HEIGHT));
    ld_addr_d = AW'(32'(src_row_i) * 32'(MAX_WIDTH) + 32'(src_col_i));
  end

  // stage 3: rotate, round half up, floor split, bound check
  always_comb begin
    sx_d = $signed({8'b0, cfg_i.center_x, 14'b0}) + SW'(pxc_q) - SW'(pys_q) + HALF;
    sy_d = $signed({8'b0, cfg_i.center_y, 14'b0}) + SW'(pxs_q) + SW'(pyc_q) + HALF;
    x0_d = sx_d[SW-1:18];
    y0_d = sy_d[SW-1:18];
    w_eff = ({9'b0, cfg_i.image_width} < 18'(MAX_WIDTH)) ?
            $signed({9'b0, cfg_i.image_width}) : $signed(18'(MAX_WIDTH));
    h_eff = ({9'b0, cfg_i.image_height} < 18'(MAX_HEIGHT)) ?
            $signed({9'b0, cfg_i.image_height}) : $signed(18'(MAX_HEIGHT));
    x0p1 = $signed({{2{x0_d[15]}}, x0_d}) + 18'sd1;
    y0p1 = $signed({{2{y0_d[15]}}, y0_d}) + 18'sd1;
    inside_d = !x0_d[15] && !y0_d[15] && (x0p1 < w_eff) && (y0p1 < h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      q1_q    <= mode_i;
      ok1_q   <= ld_ok_d;
      addr1_q <= ld_addr_d;
      pix1_q  <= pixel_i;
      dx1_q   <= dx_d;
      dy1_q   <= dy_d;
    end
    if (rdy2 && v1_q) begin
      q2_q    <= q1_q;
      ok2_q   <= ok1_q;
      addr2_q <= addr1_q;
      pix2_q  <= pix1_q;
      pxc_q   <= dx1_q * cfg_i.cos_value;
      pys_q   <= dy1_q * cfg_i.sin_value;
      pxs_q   <= dx1_q * cfg_i.sin_value;
      pyc_q   <= dy1_q * cfg_i.cos_value;
    end
    if (rdy3 && v2_q) begin
      query_o   <= q2_q;
      ld_ok_o   <= ok2_q;
      ld_addr_o <= addr2_q;
      pixel_o   <= pix2_q;
      inside_o  <= inside_d;
      x0_o      <= x0_d[XW-1:0];
      y0_o      <= y0_d[YW-1:0];
      fx_o      <= sx_d[17:RS];
      fy_o      <= sy_d[17:RS];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bir_store.sv
// Image memory with load writes and the four-read neighbour sequencer.
`default_nettype none

module bir_store #(
  parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bir_pkg::FRAC_BITS_DEF,
  localparam int XW    = $clog2(MAX_WIDTH),
  localparam int YW    = $clog2(MAX_HEIGHT),
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 query_i,
  input  logic                 ld_ok_i,
  input  logic [AW-1:0]        ld_addr_i,
  input  logic [7:0]           pixel_i,
  input  logic                 inside_i,
  input  logic [XW-1:0]        x0_i,
  input  logic [YW-1:0]        y0_i,
  input  logic [FRAC_BITS-1:0] fx_i,
  input  logic [FRAC_BITS-1:0] fy_i,
  input  logic                 credit_ok_i,
  output logic                 take_qry_o,
  output bir_pkg::tap_t        tap_o,
  output logic [7:0]           pix_o,
  output logic [FRAC_BITS-1:0] fx_o,
  output logic [FRAC_BITS-1:0] fy_o
);
  import bir_pkg::*;

  logic [7:0] mem_q [DEPTH];

  logic                 busy_q, busy_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 inside_q;
  logic [XW-1:0]        x0_q;
  logic [YW-1:0]        y0_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;

  logic          beat_last, can_take, take, wr_en, rd_en;
  logic [XW-1:0] xa;
  logic [YW-1:0] ya;
  logic [AW-1:0] rd_addr;
  tap_t          tap_q;

  assign beat_last  = !inside_q || (cnt_q == TAP_BR);
  assign can_take   = !busy_q || beat_last;
  assign ready_o    = can_take && (!query_i || credit_ok_i);
  assign take       = valid_i && ready_o;
  assign take_qry_o = take && query_i;
  assign wr_en      = take && !query_i && ld_ok_i;
  assign rd_en      = busy_q && inside_q;

  // neighbour address: low count bit steps the column, high bit the row
  assign xa      = x0_q + XW'(cnt_q[0]);
  assign ya      = y0_q + YW'(cnt_q[1]);
  assign rd_addr = AW'(32'(ya) * 32'(MAX_WIDTH) + 32'(xa));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (take_qry_o) begin
      busy_d = 1'b1;
      cnt_d  = TAP_TL;
    end else if (busy_q && beat_last) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= TAP_TL;
      tap_q  <= '0;
    end else begin
      busy_q         <= busy_d;
      cnt_q          <= cnt_d;
      tap_q.valid    <= busy_q;
      tap_q.last     <= beat_last;
      tap_q.idx      <= cnt_q;
      tap_q.in_image <= inside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_qry_o) begin
      inside_q <= inside_i;
      x0_q     <= x0_i;
      y0_q     <= y0_i;
      fx_q     <= fx_i;
      fy_q     <= fy_i;
    end
    fx_o <= fx_q;
    fy_o <= fy_q;
  end

  // read before write on a shared address keeps item order
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[ld_addr_i] <= pixel_i;
    if (rd_en) pix_o <= mem_q[rd_addr];
  end

  assign tap_o = tap_q;

endmodule

`default_nettype wire

FILE: rtl/core/bir_interp.sv
// Bilinear blend of the four neighbours and the result queue.
`default_nettype none

module bir_interp #(
  parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bir_pkg::tap_t        tap_i,
  input  logic [7:0]           pix_i,
  input  logic [FRAC_BITS-1:0] fx_i,
  input  logic [FRAC_BITS-1:0] fy_i,
  input  logic                 take_qry_i,
  output logic                 credit_ok_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [15:0]          pixel_out_o,
  output logic                 inside_res_o
);
  import bir_pkg::*;

  localparam int TW  = 8 + FRAC_BITS;
  localparam int VW  = 8 + 2 * FRAC_BITS;
  localparam int RW  = VW + 1;
  localparam int SH  = 2 * FRAC_BITS - 8;
  localparam int RND = (SH > 0) ? 2 ** (SH - 1) : 0;
  localparam int PTW = $clog2(OUT_DEPTH);
  localparam int CW  = $clog2(OUT_DEPTH + 1);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(2 ** FRAC_BITS);

  logic [7:0]           p_tl_q, p_tr_q, p_bl_q;
  logic                 va_q, ins_a_q;
  logic [TW-1:0]        top_q, bot_q;
  logic [FRAC_BITS-1:0] fy_a_q;

  logic [TW-1:0] top_d, bot_d;
  logic [VW-1:0] val;
  logic [RW-1:0] rnd;
  logic [15:0]   res;

  logic [15:0]    q_pix_q [OUT_DEPTH];
  logic           q_ins_q [OUT_DEPTH];
  logic [PTW-1:0] wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q, cred_q;
  logic           pop;

  // gather the first three neighbours
  always_ff @(posedge clk_i) begin
    if (tap_i.valid) begin
      case (tap_i.idx)
        TAP_TL:  p_tl_q <= pix_i;
        TAP_TR:  p_tr_q <= pix_i;
        TAP_BL:  p_bl_q <= pix_i;
        default: ;
      endcase
    end
  end

  // horizontal blend as the last neighbour arrives
  always_comb begin
    top_d = TW'(p_tl_q) * TW'(ONE - (FRAC_BITS + 1)'(fx_i)) + TW'(p_tr_q) * TW'(fx_i);
    bot_d = TW'(p_bl_q) * TW'(ONE - (FRAC_BITS + 1)'(fx_i)) + TW'(pix_i) * TW'(fx_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= tap_i.valid && tap_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (tap_i.valid && tap_i.last) begin
      ins_a_q <= tap_i.in_image;
      top_q   <= top_d;
      bot_q   <= bot_d;
      fy_a_q  <= fy_i;
    end
  end

  // vertical blend, round half up, saturate
  always_comb begin
    val = VW'(VW'(top_q) * VW'(ONE - (FRAC_BITS + 1)'(fy_a_q))) +
          VW'(VW'(bot_q) * VW'(fy_a_q));
    rnd = (RW'(val) + RW'(RND)) >> SH;
    res = (rnd > RW'(16'hFFFF)) ? 16'hFFFF : rnd[15:0];
  end

  // result queue; credits bound queries in flight to its depth
  assign pop          = valid_o && ready_i;
  assign valid_o      = (cnt_q != '0);
  assign credit_ok_o  = (cred_q != '0);
  assign pixel_out_o  = q_pix_q[rptr_q];
  assign inside_res_o = q_ins_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (va_q) begin
      q_pix_q[wptr_q] <= ins_a_q ? res : 16'h0000;
      q_ins_q[wptr_q] <= ins_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      cred_q <= CW'(OUT_DEPTH);
    end else begin
      if (va_q) wptr_q <= wptr_q + PTW'(1);
      if (pop)  rptr_q <= rptr_q + PTW'(1);
      cnt_q  <= cnt_q + CW'(va_q) - CW'(pop);
      cred_q <= cred_q - CW'(take_qry_i) + CW'(pop);
    end
  end

endmodule

`default_nettype wire
